FILE: hw/rtl/wspa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wspa_pkg: shared types and constants of the wheel speed PID
// Payload structs, control register codes, reset values and sequencer states.
// ----------------------------------------------------------------------------
package wspa_pkg;

   typedef struct packed {
      logic               wheel;
      logic signed [31:0] speed_ref;
      logic signed [31:0] speed_measured;
      logic        [31:0] timestamp;
   } req_type;

   typedef struct packed {
      logic               wheel_out;
      logic signed [23:0] drive_percent;
      logic               clamped;
   } rsp_type;

   // What the front hands to the back: wheel, saturated error and time.
   typedef struct packed {
      logic               wheel;
      logic signed [31:0] err;
      logic        [31:0] timestamp;
   } item_type;

   typedef struct packed {
      logic [31:0] kp;
      logic [31:0] ki;
      logic [31:0] kd;
   } gains_type;

   typedef struct packed {
      gains_type [1:0] gain;
      logic     [21:0] voltage_limit;
   } cfg_type;

   typedef enum logic [2:0] {
      CSR_KP_LEFT       = 3'd0,
      CSR_KI_LEFT       = 3'd1,
      CSR_KD_LEFT       = 3'd2,
      CSR_KP_RIGHT      = 3'd3,
      CSR_KI_RIGHT      = 3'd4,
      CSR_KD_RIGHT      = 3'd5,
      CSR_VOLTAGE_LIMIT = 3'd6
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INT_MUL,
      ST_INT_UPD,
      ST_TERM_MUL,
      ST_TERM_ACC,
      ST_CLAMP,
      ST_PCT_MUL,
      ST_DIV,
      ST_DONE
   } back_state_type;

   localparam logic [31:0] KP_RESET       = 32'd671089;
   localparam logic [31:0] KI_RESET       = 32'd11744051;
   localparam logic [31:0] KD_RESET       = 32'd671;
   localparam logic [21:0] VLIMIT_RESET   = 22'd1494221;
   // 98 percent in Q.16
   localparam logic [31:0] PCT_SCALE      = 32'd6422528;
   // Numerator of the percent division is 45 bits wide.
   localparam logic [5:0]  DIV_TOP_BIT    = 6'd44;

endpackage

`default_nettype wire

FILE: hw/rtl/wheel_speed_pid_antiwindup.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wheel_speed_pid_antiwindup: two-wheel speed PID with anti-windup
// Front end queues requests, back end runs the PID step per wheel.
// ----------------------------------------------------------------------------
//   channel   ports                                 moves
//   request   req_push / req_full / req_data        one sample word
//   response  rsp_empty / rsp_pop / rsp_data        one drive command word
//   control   csr_valid / csr_ready / csr_index     one register word
//
// The back end runs each word through the shared 32x32 multiplier, then the
// bit-serial percent divider. Two requests queue in front, so pushes continue
// while a command waits. Reset is synchronous and clears all per-wheel state
// and the registers.
// ----------------------------------------------------------------------------
module wheel_speed_pid_antiwindup (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_push,
   output      logic              req_full,
   input  wire wspa_pkg::req_type req_data,
   output      logic              rsp_empty,
   input  wire logic              rsp_pop,
   output      wspa_pkg::rsp_type rsp_data,
   input  wire logic              csr_valid,
   output      logic              csr_ready,
   input  wire logic [2:0]        csr_index,
   input  wire logic [31:0]       csr_data
);
   import wspa_pkg::*;

   cfg_type    cfg;
   logic [1:0] ki_arm;
   logic       q_valid;
   logic       q_pop;
   item_type   q_item;

   wspa_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg),
      .ki_arm    (ki_arm)
   );

   wspa_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .q_valid  (q_valid),
      .q_pop    (q_pop),
      .q_item   (q_item)
   );

   wspa_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .ki_arm    (ki_arm),
      .q_valid   (q_valid),
      .q_pop     (q_pop),
      .q_item    (q_item),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

FILE: hw/rtl/wspa_csr.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wspa_csr: control registers
// Holds the per-wheel gains and the voltage limit; flags ki writes.
// ----------------------------------------------------------------------------
module wspa_csr (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           csr_valid,
   output      logic           csr_ready,
   input  wire logic [2:0]     csr_index,
   input  wire logic [31:0]    csr_data,
   output      wspa_pkg::cfg_type cfg,
   output      logic [1:0]     ki_arm
);
   import wspa_pkg::*;

   cfg_type cfg_ff;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      ki_arm[0] = csr_valid && (csr_index == CSR_KI_LEFT);
      ki_arm[1] = csr_valid && (csr_index == CSR_KI_RIGHT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain[0].kp    <= KP_RESET;
         cfg_ff.gain[0].ki    <= KI_RESET;
         cfg_ff.gain[0].kd    <= KD_RESET;
         cfg_ff.gain[1].kp    <= KP_RESET;
         cfg_ff.gain[1].ki    <= KI_RESET;
         cfg_ff.gain[1].kd    <= KD_RESET;
         cfg_ff.voltage_limit <= VLIMIT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_KP_LEFT:       cfg_ff.gain[0].kp    <= csr_data;
            CSR_KI_LEFT:       cfg_ff.gain[0].ki    <= csr_data;
            CSR_KD_LEFT:       cfg_ff.gain[0].kd    <= csr_data;
            CSR_KP_RIGHT:      cfg_ff.gain[1].kp    <= csr_data;
            CSR_KI_RIGHT:      cfg_ff.gain[1].ki    <= csr_data;
            CSR_KD_RIGHT:      cfg_ff.gain[1].kd    <= csr_data;
            CSR_VOLTAGE_LIMIT: cfg_ff.voltage_limit <= csr_data[21:0];
            default:           ;
         endcase
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/wspa_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wspa_front: input stage and item queue
// Forms the saturated speed error and queues two words for the back end.
// ----------------------------------------------------------------------------
module wspa_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_push,
   output      logic              req_full,
   input  wire wspa_pkg::req_type req_data,
   output      logic              q_valid,
   input  wire logic              q_pop,
   output      wspa_pkg::item_type q_item
);
   import wspa_pkg::*;

   item_type          entries_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   logic signed [32:0] diff;
   item_type          new_item;
   logic              push_ok, pop_ok;

   assign req_full = (count_ff == 2'd2);
   assign q_valid  = (count_ff != 2'd0);
   assign q_item   = entries_ff[rd_ptr_ff];
   assign push_ok  = req_push && !req_full;
   assign pop_ok   = q_pop && q_valid;

   always_comb begin
      diff = 33'(req_data.speed_ref) - 33'(req_data.speed_measured);
      new_item.wheel     = req_data.wheel;
      new_item.timestamp = req_data.timestamp;
      // Clip the 33-bit difference back into the signed 32-bit range.
      if (diff[32] != diff[31]) begin
         new_item.err = diff[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
         new_item.err = diff[31:0];
      end
      wr_ptr_in = push_ok ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop_ok ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push_ok} - {1'b0, pop_ok};
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         entries_ff[wr_ptr_ff] <= new_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/wspa_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wspa_back: PID sequencer
// Per-wheel state, one shared 32x32 multiplier, clamp and a serial divider.
// ----------------------------------------------------------------------------
module wspa_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire wspa_pkg::cfg_type  cfg,
   input  wire logic [1:0]         ki_arm,
   input  wire logic               q_valid,
   output      logic               q_pop,
   input  wire wspa_pkg::item_type q_item,
   output      logic               rsp_empty,
   input  wire logic               rsp_pop,
   output      wspa_pkg::rsp_type  rsp_data
);
   import wspa_pkg::*;

   localparam logic [1:0] TERM_P = 2'd0;
   localparam logic [1:0] TERM_I = 2'd1;
   localparam logic [1:0] TERM_D = 2'd2;

   back_state_type     state_ff, state_in;
   item_type           item_ff, item_in;
   logic signed [47:0] integral_ff [2];
   logic               sat_ff [2];
   logic        [31:0] prev_time_ff [2];
   logic signed [31:0] prev_err_ff [2];
   logic        [1:0]  clear_ff, clear_in;

   logic        [63:0] prod_ff;
   logic        [31:0] mul_a, mul_b;
   logic               dtz_ff, dtz_in;
   logic        [1:0]  ti_ff, ti_in;
   logic               hl_ff, hl_in;
   logic        [56:0] term_ff, term_in;
   logic signed [59:0] u_ff, u_in;
   logic        [21:0] lim_ff, lim_in;
   logic        [21:0] magu_ff, magu_in;
   logic               neg_ff, neg_in;
   logic               clamped_ff, clamped_in;
   logic        [22:0] rem_ff, rem_in;
   logic        [23:0] quot_ff, quot_in;
   logic        [5:0]  bit_ff, bit_in;
   rsp_type            rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic               w;
   logic        [31:0] dt;
   logic        [31:0] mag_e;
   logic signed [47:0] integ;
   logic signed [32:0] derr;
   logic        [47:0] tmag;
   logic               tneg;
   gains_type          g;
   logic        [31:0] tgain;
   logic        [23:0] piece;
   logic signed [48:0] isum;
   logic        [43:0] inc;
   logic signed [47:0] int_new;
   logic               upd_int, upd_hist;
   logic        [56:0] tsum;
   logic signed [59:0] tsigned;
   logic signed [59:0] lim_s;
   logic signed [59:0] absu;
   logic        [22:0] rem_sh;

   assign rsp_empty = !rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      w     = item_ff.wheel;
      g     = cfg.gain[w];
      integ = integral_ff[w];
      dt    = item_ff.timestamp - prev_time_ff[w];
      mag_e = item_ff.err[31] ? 32'(-item_ff.err) : 32'(item_ff.err);
      derr  = 33'(item_ff.err) - 33'(prev_err_ff[w]);
      unique case (ti_ff)
         TERM_I: begin
            tgain = g.ki;
            tneg  = integ[47];
            tmag  = integ[47] ? 48'(-integ) : 48'(integ);
         end
         TERM_D: begin
            tgain = g.kd;
            tneg  = derr[32];
            tmag  = derr[32] ? 48'(-derr) : 48'(derr);
         end
         default: begin
            tgain = g.kp;
            tneg  = item_ff.err[31];
            tmag  = {16'd0, mag_e};
         end
      endcase
      piece = hl_ff ? tmag[23:0] : tmag[47:24];

      // Integral update: add the increment, saturate to 48 bits; hold after clamp, zero after ki write.
      inc  = prod_ff[63:20];
      isum = 49'(integ) + (item_ff.err[31] ? -49'(inc) : 49'(inc));
      if (isum[48] != isum[47]) begin
         int_new = isum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
      end else begin
         int_new = isum[47:0];
      end
      if (sat_ff[w]) begin
         int_new = integ;
      end
      if (clear_ff[w]) begin
         int_new = '0;
      end

      tsum    = term_ff + 57'(prod_ff[55:24]);
      tsigned = tneg ? -60'(tsum) : 60'(tsum);
      lim_s   = 60'(lim_ff);
      absu    = u_ff[59] ? -u_ff : u_ff;
      rem_sh  = {rem_ff[21:0], prod_ff[bit_ff]};

      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_INT_MUL: begin
            mul_a = dt;
            mul_b = mag_e;
         end
         ST_TERM_MUL: begin
            mul_a = tgain;
            mul_b = {8'd0, piece};
         end
         ST_PCT_MUL: begin
            mul_a = {10'd0, magu_ff};
            mul_b = PCT_SCALE;
         end
         default: ;
      endcase

      state_in     = state_ff;
      item_in      = item_ff;
      clear_in     = clear_ff | ki_arm;
      dtz_in       = dtz_ff;
      ti_in        = ti_ff;
      hl_in        = hl_ff;
      term_in      = term_ff;
      u_in         = u_ff;
      lim_in       = lim_ff;
      rem_in       = rem_ff;
      quot_in      = quot_ff;
      bit_in       = bit_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_pop;
      q_pop        = 1'b0;
      upd_int      = 1'b0;
      upd_hist     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               item_in  = q_item;
               state_in = ST_INT_MUL;
            end
         end
         ST_INT_MUL: begin
            dtz_in   = (dt == 32'd0);
            state_in = ST_INT_UPD;
         end
         ST_INT_UPD: begin
            upd_int     = 1'b1;
            clear_in[w] = 1'b0;
            ti_in       = TERM_P;
            hl_in       = 1'b0;
            u_in        = '0;
            lim_in      = (cfg.voltage_limit == 22'd0) ? 22'd1 : cfg.voltage_limit;
            state_in    = ST_TERM_MUL;
         end
         ST_TERM_MUL: begin
            state_in = ST_TERM_ACC;
         end
         ST_TERM_ACC: begin
            state_in = ST_TERM_MUL;
            if (!hl_ff) begin
               term_in = {1'b0, prod_ff[55:0]};
               hl_in   = 1'b1;
            end else begin
               hl_in = 1'b0;
               // The derivative term drops out when no time has passed.
               if (!(ti_ff == TERM_D && dtz_ff)) begin
                  u_in = u_ff + tsigned;
               end
               if (ti_ff == TERM_D) begin
                  state_in = ST_CLAMP;
               end else begin
                  ti_in = ti_ff + 2'd1;
               end
            end
         end
         ST_CLAMP: begin
            state_in = ST_PCT_MUL;
         end
         ST_PCT_MUL: begin
            state_in = ST_DIV;
         end
         default: ;
      endcase

      // Set up the divider while the percent product forms.
      if (state_ff == ST_PCT_MUL) begin
         rem_in  = '0;
         quot_in = '0;
         bit_in  = DIV_TOP_BIT;
      end
      if (state_ff == ST_DIV) begin
         if (rem_sh >= {1'b0, lim_ff}) begin
            rem_in  = rem_sh - {1'b0, lim_ff};
            quot_in = {quot_ff[22:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            quot_in = {quot_ff[22:0], 1'b0};
         end
         if (bit_ff == 6'd0) begin
            state_in = ST_DONE;
         end else begin
            bit_in = bit_ff - 6'd1;
         end
      end
      if (state_ff == ST_DONE && !rsp_valid_ff) begin
         rsp_in.wheel_out     = w;
         rsp_in.drive_percent = neg_ff ? -quot_ff : quot_ff;
         rsp_in.clamped       = clamped_ff;
         rsp_valid_in         = 1'b1;
         upd_hist             = 1'b1;
         state_in             = ST_IDLE;
      end
   end

   // Clamp stage: bounds the sum by the limit latched in ST_INT_UPD, registered in ST_CLAMP.
   always_comb begin
      if (u_ff > lim_s) begin
         magu_in    = lim_ff;
         neg_in     = 1'b0;
         clamped_in = 1'b1;
      end else if (u_ff < -lim_s) begin
         magu_in    = lim_ff;
         neg_in     = 1'b1;
         clamped_in = 1'b1;
      end else begin
         magu_in    = absu[21:0];
         neg_in     = u_ff[59];
         clamped_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      // The divider walks the held product bit by bit.
      if (state_ff != ST_DIV) begin
         prod_ff <= mul_a * mul_b;
      end
      item_ff <= item_in;
      dtz_ff  <= dtz_in;
      ti_ff   <= ti_in;
      hl_ff   <= hl_in;
      term_ff <= term_in;
      u_ff    <= u_in;
      lim_ff  <= lim_in;
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      bit_ff  <= bit_in;
      rsp_ff  <= rsp_in;
      if (state_ff == ST_CLAMP) begin
         magu_ff    <= magu_in;
         neg_ff     <= neg_in;
         clamped_ff <= clamped_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         clear_ff     <= '0;
         for (int i = 0; i < 2; i++) begin
            integral_ff[i]  <= '0;
            sat_ff[i]       <= 1'b0;
            prev_time_ff[i] <= '0;
            prev_err_ff[i]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         clear_ff     <= clear_in;
         if (upd_int) begin
            integral_ff[w] <= int_new;
         end
         if (upd_hist) begin
            sat_ff[w]       <= clamped_ff;
            prev_time_ff[w] <= item_ff.timestamp;
            prev_err_ff[w]  <= item_ff.err;
         end
      end
   end

endmodule

`default_nettype wire

FILE: verif/wheel_speed_pid_antiwindup_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wheel_speed_pid_antiwindup_checker: drive command predictor and comparator
// Watches the request, response and control channels of the wheel speed PID,
// keeps its own copy of gains and per-wheel state, predicts each drive
// command word and compares it with what the block delivers.
// ----------------------------------------------------------------------------
module wheel_speed_pid_antiwindup_checker (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_push,
   input  wire logic              req_full,
   input  wire wspa_pkg::req_type req_data,
   input  wire logic              rsp_empty,
   input  wire logic              rsp_pop,
   input  wire wspa_pkg::rsp_type rsp_data,
   input  wire logic              csr_valid,
   input  wire logic              csr_ready,
   input  wire logic [2:0]        csr_index,
   input  wire logic [31:0]       csr_data,
   output int                     fail_count,
   output int                     pending_count
);
   import wspa_pkg::*;

   localparam longint INT48_HI = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint INT48_LO = -64'sh0000_8000_0000_0000;

   logic [31:0] kp [2];
   logic [31:0] ki [2];
   logic [31:0] kd [2];
   logic [21:0] vlimit;
   longint      integ [2];
   logic        sat [2];
   logic [31:0] last_time [2];
   logic signed [31:0] last_err [2];
   logic        clr_armed [2];

   rsp_type expected_cmds [$];

   assign pending_count = expected_cmds.size();

   // Gain times value, shifted down by 24 with truncation toward zero.
   function automatic longint scale_gain(logic [31:0] k, longint x);
      logic [63:0] m, hi, lo, r;
      m  = x < 0 ? -x : x;
      hi = m >> 24;
      lo = m & 64'hFF_FFFF;
      r  = {32'd0, k} * hi + (({32'd0, k} * lo) >> 24);
      return x < 0 ? -longint'(r) : longint'(r);
   endfunction

   function automatic rsp_type predict_drive(req_type rq);
      int          w;
      longint      e, s, u, lim, pct;
      logic [31:0] dt;
      logic [63:0] inc, mag;
      logic        clip;
      rsp_type     r;
      w    = rq.wheel;
      e    = longint'(rq.speed_ref) - longint'(rq.speed_measured);
      if (e > 64'sd2147483647) e = 64'sd2147483647;
      if (e < -64'sd2147483648) e = -64'sd2147483648;
      dt   = rq.timestamp - last_time[w];
      clip = 1'b0;
      if (!sat[w]) begin
         inc = ({32'd0, dt} * (e < 0 ? -e : e)) >> 20;
         s   = integ[w] + (e < 0 ? -longint'(inc) : longint'(inc));
         if (s > INT48_HI) s = INT48_HI;
         if (s < INT48_LO) s = INT48_LO;
         integ[w] = s;
      end
      if (clr_armed[w]) begin
         integ[w]     = 0;
         clr_armed[w] = 1'b0;
      end
      u = scale_gain(kp[w], e) + scale_gain(ki[w], integ[w]);
      if (dt != 0) u += scale_gain(kd[w], e - longint'(last_err[w]));
      lim = vlimit == 0 ? 1 : longint'({42'd0, vlimit});
      if (u > lim) begin
         u    = lim;
         clip = 1'b1;
      end else if (u < -lim) begin
         u    = -lim;
         clip = 1'b1;
      end
      mag = u < 0 ? -u : u;
      pct = longint'((mag * 64'd6422528) / lim);
      if (u < 0) pct = -pct;
      sat[w]       = clip;
      last_time[w] = rq.timestamp;
      last_err[w]  = e[31:0];
      r.wheel_out     = rq.wheel;
      r.drive_percent = pct[23:0];
      r.clamped       = clip;
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int w = 0; w < 2; w++) begin
            kp[w]        = KP_RESET;
            ki[w]        = KI_RESET;
            kd[w]        = KD_RESET;
            integ[w]     = 0;
            sat[w]       = 1'b0;
            last_time[w] = '0;
            last_err[w]  = '0;
            clr_armed[w] = 1'b0;
         end
         vlimit = VLIMIT_RESET;
         expected_cmds.delete();
         fail_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_KP_LEFT: kp[0] = csr_data;
               CSR_KI_LEFT: begin
                  ki[0]        = csr_data;
                  clr_armed[0] = 1'b1;
               end
               CSR_KD_LEFT: kd[0] = csr_data;
               CSR_KP_RIGHT: kp[1] = csr_data;
               CSR_KI_RIGHT: begin
                  ki[1]        = csr_data;
                  clr_armed[1] = 1'b1;
               end
               CSR_KD_RIGHT: kd[1] = csr_data;
               CSR_VOLTAGE_LIMIT: vlimit = csr_data[21:0];
               default: ;
            endcase
         end
         if (req_push && !req_full) expected_cmds.push_back(predict_drive(req_data));
         if (rsp_pop && !rsp_empty) begin
            if (expected_cmds.size() == 0) begin
               $error("unexpected drive command word %h", rsp_data);
               fail_count++;
            end else begin
               want = expected_cmds.pop_front();
               if (rsp_data.wheel_out !== want.wheel_out) begin
                  $error("wheel_out expected %0d actual %0d", want.wheel_out,
                         rsp_data.wheel_out);
                  fail_count++;
               end
               if (rsp_data.drive_percent !== want.drive_percent) begin
                  $error("drive_percent expected %0d actual %0d",
                         want.drive_percent, rsp_data.drive_percent);
                  fail_count++;
               end
               if (rsp_data.clamped !== want.clamped) begin
                  $error("clamped expected %0d actual %0d", want.clamped,
                         rsp_data.clamped);
                  fail_count++;
               end
            end
         end
      end
   end
endmodule

FILE: verif/wheel_speed_pid_antiwindup_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wheel_speed_pid_antiwindup_tb: regression bench for the wheel speed PID
// Directed extremes, then random sample words in bursts over several gain
// and limit settings, with a stalling response side. The checker predicts.
// ----------------------------------------------------------------------------
module wheel_speed_pid_antiwindup_tb;
   import wspa_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   req_type     req_data = '0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_data = '0;
   int          fail_count;
   int          pending_count;
   int          cycle_count = 0;
   logic [31:0] stamp [2] = '{default: '0};

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   wheel_speed_pid_antiwindup uut (.*);
   wheel_speed_pid_antiwindup_checker checker_i (.*);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Response side: stretches of steady popping alternate with random stalls.
   always @(posedge clock) begin
      if (reset) rsp_pop <= 1'b0;
      else if (cycle_count[11:9] == 3'd2) rsp_pop <= 1'b1;
      else rsp_pop <= ($urandom_range(0, 3) != 0);
   end

   // Each task drops the other channel's valid, so a handshake signal is
   // assigned only once per clock edge between calls.
   task automatic write_reg(csr_index_type idx, logic [31:0] val);
      req_push  <= 1'b0;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic send_sample(logic w, logic [31:0] sref, logic [31:0] smeas,
                              logic [31:0] ts);
      csr_valid <= 1'b0;
      req_push  <= 1'b1;
      req_data  <= '{wheel: w, speed_ref: sref, speed_measured: smeas, timestamp: ts};
      @(posedge clock);
      while (req_full) @(posedge clock);
   endtask

   task automatic drain_all();
      req_push  <= 1'b0;
      csr_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   // Mostly realistic speeds with advancing time, some wild values.
   task automatic send_random(int count);
      logic        w;
      logic [31:0] sref, smeas;
      int          burst;
      burst = 0;
      for (int i = 0; i < count; i++) begin
         w = $urandom_range(0, 1);
         if ($urandom_range(0, 9) < 7) begin
            sref  = $signed($urandom_range(0, 2 * 6553600)) - 6553600;
            smeas = sref + $signed($urandom_range(0, 655360)) - 327680;
            stamp[w] = stamp[w] + $urandom_range(0, 4000);
         end else begin
            sref  = $urandom;
            smeas = $urandom;
            stamp[w] = $urandom;
         end
         send_sample(w, sref, smeas, stamp[w]);
         if (burst == 0) begin
            burst = $urandom_range(1, 12);
            req_push <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge clock);
         end else begin
            burst--;
         end
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: first steps, extremes, zero dt, error saturation.
      send_sample(1'b0, 32'sd655360, 32'sd0, 32'd1000);
      send_sample(1'b1, -32'sd655360, 32'sd0, 32'd0);
      send_sample(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'd1000);
      send_sample(1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      send_sample(1'b0, 32'h8000_0000, 32'h8000_0000, 32'd5000);
      send_sample(1'b1, 32'd0, 32'd0, 32'd10);
      drain_all();
      write_reg(CSR_KI_LEFT, 32'd0);
      write_reg(CSR_KI_RIGHT, 32'hFFFF_FFFF);
      write_reg(CSR_KP_LEFT, 32'hFFFF_FFFF);
      write_reg(CSR_KD_LEFT, 32'hFFFF_FFFF);
      write_reg(CSR_KP_RIGHT, 32'd0);
      write_reg(CSR_KD_RIGHT, 32'd0);
      write_reg(CSR_VOLTAGE_LIMIT, 32'd0);
      send_sample(1'b0, 32'sd65536, 32'sd0, 32'd6000);
      send_sample(1'b1, 32'sd65536, 32'sd0, 32'd100);
      send_sample(1'b0, -32'sd65536, 32'sd0, 32'd7000);
      drain_all();
      write_reg(CSR_VOLTAGE_LIMIT, 32'h003F_FFFF);
      write_reg(CSR_KI_RIGHT, 32'hFFFF_FFFF);
      send_sample(1'b1, 32'sd1000, 32'sd0, 32'd200);
      send_sample(1'b1, -32'sd1000, 32'sd0, 32'd300);
      drain_all();

      for (int phase = 0; phase < 4; phase++) begin
         write_reg(CSR_KP_LEFT, phase == 3 ? 32'd671089 : $urandom_range(0, 4000000));
         write_reg(CSR_KI_LEFT, phase == 2 ? $urandom : $urandom_range(0, 20000000));
         write_reg(CSR_KD_LEFT, $urandom_range(0, 100000));
         write_reg(CSR_KP_RIGHT, phase == 1 ? $urandom : $urandom_range(0, 4000000));
         write_reg(CSR_KI_RIGHT, $urandom_range(0, 20000000));
         write_reg(CSR_KD_RIGHT, $urandom);
         write_reg(CSR_VOLTAGE_LIMIT, phase == 0 ? 32'd1 : $urandom_range(1, 4194303));
         send_random(160);
         drain_all();
      end

      if (fail_count == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end
endmodule

FILE: sim.f
hw/rtl/wspa_pkg.sv
hw/rtl/wspa_csr.sv
hw/rtl/wspa_front.sv
hw/rtl/wspa_back.sv
hw/rtl/wheel_speed_pid_antiwindup.sv
verif/wheel_speed_pid_antiwindup_checker.sv
verif/wheel_speed_pid_antiwindup_tb.sv
